// File: rtl/pressure_temperature_compensation_defines.svh
// ----------------------------------------------------------------------------
// pressure temperature compensation assertion macros
// shared assertion forms on clk with synchronous reset rst
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// condition implies consequence in the same cycle
`define PTC_ASSERT_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PTC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// types and constants of the pressure temperature compensation block
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned CfgW = 48;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_A1_A2_A3 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_A4_A5_A6 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_B1_B2    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MC_MD    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OSS      = 3'd4;

  localparam logic [31:0] TEMP_OFFSET = 32'd4000;
  localparam logic [31:0] P_SCALE     = 32'd50000;
  localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;
  localparam logic [31:0] K_SQ        = 32'd3038;
  localparam logic [31:0] K_LIN       = 32'hFFFF_E343; // -7357
  localparam logic [31:0] K_BIAS      = 32'd3791;
  localparam logic [31:0] K_HALF      = 32'd32768;

  // request to the serial arithmetic unit
  typedef struct packed {
    logic start;
    logic op_div;
  } unit_req_t;

endpackage

// File: rtl/ptc_stream_if.sv
// ----------------------------------------------------------------------------
// ptc stream interfaces
// reading channel and result channel with valid and ready
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [23:0] raw_reading;
  modport source (output valid, func, raw_reading, input ready);
  modport sink (input valid, func, raw_reading, output ready);
endinterface

interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               divide_error;
  modport source (output valid, value, divide_error, input ready);
  modport sink (input valid, value, divide_error, output ready);
endinterface

// File: rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// calibrated temperature and pressure from raw sensor readings
// ----------------------------------------------------------------------------
// operations: temperature two serial operations (multiply, divide), pressure eleven
//   serial operations, fewer on a zero divisor
// flow: one reading at a time on the single bit-serial mul/div unit; a new reading
//   is taken only after the result has been handed to the output register
// reset: synchronous; coefficients clear, oversampling to 1, kept term to 0
module pressure_temperature_compensation
  import ptc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  ptc_in_if.sink              sample,
  ptc_out_if.source           result,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

`include "pressure_temperature_compensation_defines.svh"

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_T_MUL = 4'd1;
  localparam logic [3:0] S_T_DIV = 4'd2;
  localparam logic [3:0] S_P_SQ  = 4'd3;
  localparam logic [3:0] S_P_X1  = 4'd4;
  localparam logic [3:0] S_P_X2  = 4'd5;
  localparam logic [3:0] S_P_X3  = 4'd6;
  localparam logic [3:0] S_P_X4  = 4'd7;
  localparam logic [3:0] S_P_B4  = 4'd8;
  localparam logic [3:0] S_P_B7  = 4'd9;
  localparam logic [3:0] S_P_DIV = 4'd10;
  localparam logic [3:0] S_P_Q1  = 4'd11;
  localparam logic [3:0] S_P_Q2  = 4'd12;
  localparam logic [3:0] S_P_Q3  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] s);
    asr = $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // calibration registers
  logic [47:0] c_a123;
  logic [47:0] c_a456;
  logic [31:0] c_b12;
  logic [31:0] c_mcmd;
  logic [1:0]  oss;
  logic [31:0] temp_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_a123 <= '0;
      c_a456 <= '0;
      c_b12  <= '0;
      c_mcmd <= '0;
      oss    <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_A1_A2_A3: c_a123 <= cfg_data;
        REG_A4_A5_A6: c_a456 <= cfg_data;
        REG_B1_B2:    c_b12  <= cfg_data[31:0];
        REG_MC_MD:    c_mcmd <= cfg_data[31:0];
        REG_OSS:      oss    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // coefficient views
  logic [31:0] a1, a2, a3, a4, a5, a6, b1, b2, mc, md;
  assign a1 = sx16(c_a123[15:0]);
  assign a2 = sx16(c_a123[31:16]);
  assign a3 = sx16(c_a123[47:32]);
  assign a4 = {16'd0, c_a456[15:0]};
  assign a5 = {16'd0, c_a456[31:16]};
  assign a6 = {16'd0, c_a456[47:32]};
  assign b1 = sx16(c_b12[15:0]);
  assign b2 = sx16(c_b12[31:16]);
  assign mc = sx16(c_mcmd[15:0]);
  assign md = sx16(c_mcmd[31:16]);

  // working registers
  logic [3:0]  state;
  logic        issued;
  logic [23:0] raw;
  logic [31:0] t1, sq, b3, b4, b7, p;
  logic [31:0] res_val;
  logic        res_err;

  // serial unit
  unit_req_t   req;
  logic [31:0] op_a, op_b;
  logic        u_done;
  logic [31:0] u_res;

  ptc_serial_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (op_a),
    .b      (op_b),
    .done   (u_done),
    .result (u_res)
  );

  // derived values
  logic [31:0] ut, up, b6, num, num_abs, den_abs, q_t;
  logic [31:0] x1_t, den_t, x3_lo, b3_arg, b3_new, x3_hi, b5, sum_q;
  logic [31:0] scale;

  assign ut      = {16'd0, raw[15:0]};
  assign up      = {8'd0, raw} >> (4'd8 - {2'd0, oss});
  assign b6      = temp_term - TEMP_OFFSET;
  assign num     = mc << 11;
  assign num_abs = num[31] ? (32'd0 - num) : num;
  assign den_abs = b4[31] ? (32'd0 - b4) : b4;
  assign q_t     = (num[31] ^ b4[31]) ? (32'd0 - u_res) : u_res;
  assign x1_t    = asr(u_res, 5'd15);
  assign den_t   = x1_t + md;
  assign b5      = t1 + q_t;
  assign x3_lo   = t1 + asr(u_res, 5'd11);
  assign b3_arg  = ((a1 << 2) + x3_lo << oss) + 32'd2;
  // truncating divide by four
  assign b3_new  = b3_arg[31] ? asr(b3_arg + 32'd3, 5'd2) : asr(b3_arg, 5'd2);
  assign x3_hi   = asr(t1 + asr(u_res, 5'd16) + 32'd2, 5'd2);
  assign scale   = P_SCALE >> oss;
  assign sum_q   = p + asr(t1 + asr(u_res, 5'd16) + K_BIAS, 5'd4);

  // operand selection per step
  always_comb begin
    req.op_div = 1'b0;
    op_a       = '0;
    op_b       = '0;
    unique case (state)
      S_T_MUL: begin op_a = ut - a6; op_b = a5; end
      S_T_DIV: begin req.op_div = 1'b1; op_a = num_abs; op_b = den_abs; end
      S_P_SQ:  begin op_a = b6; op_b = b6; end
      S_P_X1:  begin op_a = b2; op_b = sq; end
      S_P_X2:  begin op_a = a2; op_b = b6; end
      S_P_X3:  begin op_a = a3; op_b = b6; end
      S_P_X4:  begin op_a = b1; op_b = sq; end
      S_P_B4:  begin op_a = a4; op_b = t1; end
      S_P_B7:  begin op_a = up - b3; op_b = scale; end
      S_P_DIV: begin
        // double before dividing unless doubling would overflow, else double the quotient
        req.op_div = 1'b1;
        op_a       = (b7 < HALF_RANGE) ? (b7 << 1) : b7;
        op_b       = b4;
      end
      S_P_Q1:  begin op_a = asr(p, 5'd8); op_b = asr(p, 5'd8); end
      S_P_Q2:  begin op_a = t1; op_b = K_SQ; end
      S_P_Q3:  begin op_a = p; op_b = K_LIN; end
      default: ;
    endcase
  end

  assign req.start = (state != S_IDLE) && (state != S_DONE) && !issued;

  assign sample.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      temp_term    <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_DONE) result.valid <= 1'b0;
      if (u_done) issued <= 1'b0;
      else if (req.start) issued <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (sample.valid) state <= sample.func ? S_P_SQ : S_T_MUL;
        end
        S_T_MUL: begin
          if (u_done) begin
            if (den_t == 32'd0) begin
              // zero divisor, kept term stays
              res_val <= '0;
              res_err <= 1'b1;
              state   <= S_DONE;
            end else begin
              state <= S_T_DIV;
            end
          end
        end
        S_T_DIV: begin
          if (u_done) begin
            temp_term <= b5;
            res_val   <= asr(b5 + 32'd8, 5'd4);
            res_err   <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_P_SQ:  if (u_done) state <= S_P_X1;
        S_P_X1:  if (u_done) state <= S_P_X2;
        S_P_X2:  if (u_done) state <= S_P_X3;
        S_P_X3:  if (u_done) state <= S_P_X4;
        S_P_X4:  if (u_done) state <= S_P_B4;
        S_P_B4: begin
          if (u_done) begin
            if ((u_res >> 15) == 32'd0) begin
              res_val <= '0;
              res_err <= 1'b1;
              state   <= S_DONE;
            end else begin
              state <= S_P_B7;
            end
          end
        end
        S_P_B7:  if (u_done) state <= S_P_DIV;
        S_P_DIV: if (u_done) state <= S_P_Q1;
        S_P_Q1:  if (u_done) state <= S_P_Q2;
        S_P_Q2:  if (u_done) state <= S_P_Q3;
        S_P_Q3: begin
          if (u_done) begin
            res_val <= sum_q;
            res_err <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          // hand over once the output register is free
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.value        <= $signed(res_val);
            result.divide_error <= res_err;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) raw <= sample.raw_reading;
    if (u_done) begin
      unique case (state)
        S_T_MUL: begin t1 <= x1_t; b4 <= den_t; end
        S_P_SQ:  sq <= asr(u_res, 5'd12);
        S_P_X1:  t1 <= asr(u_res, 5'd11);
        S_P_X2:  b3 <= b3_new;
        S_P_X3:  t1 <= asr(u_res, 5'd13);
        S_P_X4:  t1 <= x3_hi + K_HALF;
        S_P_B4:  b4 <= u_res >> 15;
        S_P_B7:  b7 <= u_res;
        S_P_DIV: p  <= (b7 < HALF_RANGE) ? u_res : (u_res << 1);
        S_P_Q1:  t1 <= u_res;
        S_P_Q2:  t1 <= asr(u_res, 5'd16);
        default: ;
      endcase
    end
  end

  `PTC_ASSERT_SAME(a_err_zero, result.valid && result.divide_error, result.value == 0, "error result not zero")
  `PTC_ASSERT_NEXT(a_accept_busy, sample.valid && sample.ready, state != S_IDLE, "transfer did not start work")
  `PTC_ASSERT_SAME(a_done_issued, u_done, issued, "unit finished without a request")
  `PTC_ASSERT_SAME(a_idle_quiet, state == S_IDLE, !issued, "request pending while idle")

endmodule

// File: rtl/ptc_serial_unit.sv
// ----------------------------------------------------------------------------
// ptc_serial_unit
// bit-serial shift-add multiplier (low 32 bits) and restoring unsigned divider
// ----------------------------------------------------------------------------
module ptc_serial_unit
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  unit_req_t   req,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] result
);

  logic        busy;
  logic        op_div;
  logic [4:0]  cnt;
  logic [31:0] acc;
  logic [31:0] sa;
  logic [31:0] sb;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {acc, sa[31]};
  assign diff  = trial - {1'b0, sb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op_div <= req.op_div;
      acc    <= '0;
      sa     <= a;
      sb     <= b;
    end else if (busy) begin
      if (op_div) begin
        // remainder in acc, dividend shifts out of sa as quotient shifts in
        if (!diff[32]) begin
          acc <= diff[31:0];
          sa  <= {sa[30:0], 1'b1};
        end else begin
          acc <= trial[31:0];
          sa  <= {sa[30:0], 1'b0};
        end
      end else begin
        if (sb[0]) acc <= acc + sa;
        sa <= {sa[30:0], 1'b0};
        sb <= {1'b0, sb[31:1]};
      end
    end
  end

  assign result = op_div ? sa : acc;

endmodule

// File: dv/tb_pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// tb_pressure_temperature_compensation
// drives temperature and pressure readings through the compensation block and
// checks every result against a cycle-free predictor of the integer algorithm,
// under several calibration sets, oversampling settings and idling patterns
// ----------------------------------------------------------------------------
module tb_pressure_temperature_compensation;
  import ptc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RunLimit    = 3_000_000;
  localparam int unsigned SettleWait  = 500;  // longer than a pressure computation
  localparam int unsigned HoldCycles  = 1500; // receiver hold-off stretch
  localparam int unsigned ReportLimit = 10;

  localparam logic FUNC_TEMP  = 1'b0;
  localparam logic FUNC_PRESS = 1'b1;

  typedef struct packed {
    logic signed [31:0] value;
    logic               divide_error;
  } comp_result_t;

  logic clk;
  logic rst;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  ptc_in_if  sample_if ();
  ptc_out_if result_if ();

  pressure_temperature_compensation u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the calibration registers and the kept temperature term
  logic [47:0] cal_a123;
  logic [47:0] cal_a456;
  logic [31:0] cal_b12;
  logic [31:0] cal_mcmd;
  logic [1:0]  cal_oss;
  logic [31:0] kept_b5;

  comp_result_t pending_results[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  // clock, run limit
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RunLimit) begin
      $display("tb_pressure_temperature_compensation: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
    return $signed(x) >>> s;
  endfunction

  // signed division truncating toward zero; the one overflow case wraps
  function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    sa = a;
    sb = b;
    if (a == HALF_RANGE && b == 32'hFFFF_FFFF) return a;
    return sa / sb;
  endfunction

  function automatic comp_result_t compensate_reading(input logic func,
                                                      input logic [23:0] raw);
    comp_result_t r;
    logic [31:0] ut, up, a1, a2, a3, a4, a5, a6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
    a1 = sx16(cal_a123[15:0]);
    a2 = sx16(cal_a123[31:16]);
    a3 = sx16(cal_a123[47:32]);
    a4 = {16'd0, cal_a456[15:0]};
    a5 = {16'd0, cal_a456[31:16]};
    a6 = {16'd0, cal_a456[47:32]};
    b1 = sx16(cal_b12[15:0]);
    b2 = sx16(cal_b12[31:16]);
    mc = sx16(cal_mcmd[15:0]);
    md = sx16(cal_mcmd[31:16]);
    r = '0;
    if (func == FUNC_TEMP) begin
      ut = {16'd0, raw[15:0]};
      x1 = asr((ut - a6) * a5, 15);
      den = x1 + md;
      if (den == 32'd0) begin
        r.divide_error = 1'b1;
      end else begin
        b5 = x1 + sdiv(mc << 11, den);
        kept_b5 = b5;
        r.value = asr(b5 + 32'd8, 4);
      end
    end else begin
      up = {8'd0, raw} >> (4'd8 - cal_oss);
      b6 = kept_b5 - TEMP_OFFSET;
      sq = asr(b6 * b6, 12);
      x1 = asr(b2 * sq, 11);
      x2 = asr(a2 * b6, 11);
      x3 = x1 + x2;
      b3 = sdiv(((a1 * 32'd4 + x3) << cal_oss) + 32'd2, 32'd4);
      x1 = asr(a3 * b6, 13);
      x2 = asr(b1 * sq, 16);
      x3 = asr(x1 + x2 + 32'd2, 2);
      b4 = (a4 * (x3 + K_HALF)) >> 15;
      if (b4 == 32'd0) begin
        r.divide_error = 1'b1;
      end else begin
        b7 = (up - b3) * (P_SCALE >> cal_oss);
        if (b7 < HALF_RANGE) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * K_SQ, 16);
        x2 = asr(32'd0 - (32'd7357 * p), 16);
        p = p + asr(x1 + x2 + K_BIAS, 4);
        r.value = p;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- result side
  // ready idles at random, or is held low for a counted stretch
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
      result_if.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HoldCycles;
        result_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // each transfer on the result channel against the oldest expectation
  always @(posedge clk) begin
    comp_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected result value=%0d err=%0b", result_if.value,
                   result_if.divide_error);
      end else begin
        want = pending_results.pop_front();
        if (result_if.value !== want.value ||
            result_if.divide_error !== want.divide_error) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("mismatch: expected value=%0d err=%0b, got value=%0d err=%0b",
                     want.value, want.divide_error, result_if.value,
                     result_if.divide_error);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender side
  // one reading; valid stays high into the next call when no idle is rolled
  task automatic send_reading(input logic func, input logic [23:0] raw);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.func <= func;
    sample_if.raw_reading <= raw;
    do @(posedge clk); while (!sample_if.ready);
    pending_results.push_back(compensate_reading(func, raw));
  endtask

  task automatic drain_results();
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  // all five registers back to back, only while the block is idle
  task automatic load_calibration(input logic [47:0] a123, input logic [47:0] a456,
                                  input logic [31:0] b12, input logic [31:0] mcmd,
                                  input logic [1:0] oss);
    cfg_we <= 1'b1;
    cfg_index <= REG_A1_A2_A3; cfg_data <= a123;
    @(posedge clk);
    cfg_index <= REG_A4_A5_A6; cfg_data <= a456;
    @(posedge clk);
    cfg_index <= REG_B1_B2; cfg_data <= {16'd0, b12};
    @(posedge clk);
    cfg_index <= REG_MC_MD; cfg_data <= {16'd0, mcmd};
    @(posedge clk);
    cfg_index <= REG_OSS; cfg_data <= {46'd0, oss};
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_a123 = a123;
    cal_a456 = a456;
    cal_b12 = b12;
    cal_mcmd = mcmd;
    cal_oss = oss;
  endtask

  // typical sensor calibration: ac1..ac3, ac4..ac6, b1 b2, mc md
  localparam logic [47:0] TYP_A123 = {16'hC7D1, 16'hFFB8, 16'h0198};
  localparam logic [47:0] TYP_A456 = {16'h5A71, 16'h7FF5, 16'h7FE5};
  localparam logic [31:0] TYP_B12  = {16'h0004, 16'h182E};
  localparam logic [31:0] TYP_MCMD = {16'h0B34, 16'hDDF9};

  // typical words with small random spread, or fully random words
  task automatic load_random_calibration(input logic [1:0] oss);
    logic [47:0] a123, a456;
    logic [31:0] b12, mcmd;
    if ($urandom_range(3) == 0) begin
      a123 = 48'({$urandom(), $urandom()});
      a456 = 48'({$urandom(), $urandom()});
      b12 = $urandom();
      mcmd = $urandom();
    end else begin
      a123 = TYP_A123 ^ {8'd0, 8'($urandom_range(255)), 8'd0, 8'($urandom_range(255)),
                         8'd0, 8'($urandom_range(255))};
      a456 = TYP_A456 ^ {16'($urandom_range(4095)), 16'($urandom_range(4095)),
                         16'($urandom_range(4095))};
      b12 = TYP_B12 ^ {8'd0, 8'($urandom()), 16'($urandom_range(4095))};
      mcmd = TYP_MCMD ^ {16'($urandom_range(1023)), 16'($urandom_range(4095))};
    end
    load_calibration(a123, a456, b12, mcmd, oss);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // pressure ahead of any temperature uses the cleared term
    load_calibration(TYP_A123, TYP_A456, TYP_B12, TYP_MCMD, 2'd0);
    send_reading(FUNC_PRESS, 24'd23843 << 8);
    send_reading(FUNC_TEMP, 24'd27898);
    send_reading(FUNC_PRESS, 24'd23843 << 8);
    // upper bits of a temperature reading are ignored
    send_reading(FUNC_TEMP, 24'hFF0000 | 24'd27898);
    send_reading(FUNC_TEMP, 24'h000000);
    send_reading(FUNC_TEMP, 24'hFFFFFF);
    send_reading(FUNC_PRESS, 24'h000000);
    send_reading(FUNC_PRESS, 24'hFFFFFF);
    drain_results();
    load_calibration(TYP_A123, TYP_A456, TYP_B12, TYP_MCMD, 2'd3);
    send_reading(FUNC_TEMP, 24'd27898);
    send_reading(FUNC_PRESS, 24'h5D2300);
    send_reading(FUNC_PRESS, 24'hFFFFFF);
    send_reading(FUNC_PRESS, 24'h000001);
    drain_results();
    // zero temperature divisor: a5 and md zero, kept term stays
    load_calibration(TYP_A123, {TYP_A456[47:32], 16'd0, TYP_A456[15:0]}, TYP_B12,
                     {16'd0, TYP_MCMD[15:0]}, 2'd1);
    send_reading(FUNC_TEMP, 24'd30000);
    send_reading(FUNC_PRESS, 24'h9A5C00);
    drain_results();
    // zero pressure divisor: a4 zero
    load_calibration(TYP_A123, {TYP_A456[47:16], 16'd0}, TYP_B12, TYP_MCMD, 2'd2);
    send_reading(FUNC_PRESS, 24'h9A5C00);
    send_reading(FUNC_TEMP, 24'd25000);
    send_reading(FUNC_PRESS, 24'h123456);
    drain_results();
    // extreme register words
    load_calibration('1, '1, '1, '1, 2'd3);
    send_reading(FUNC_TEMP, 24'hABCDEF);
    send_reading(FUNC_PRESS, 24'hFEDCBA);
    drain_results();
    load_calibration({16'h8000, 16'h7FFF, 16'h8000}, {16'hFFFF, 16'h8000, 16'h0001},
                     {16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000}, 2'd0);
    send_reading(FUNC_TEMP, 24'h00FFFF);
    send_reading(FUNC_PRESS, 24'h800000);
    drain_results();
  endtask

  // mostly a temperature then a few pressures, sometimes a lone reading
  task automatic random_readings(input int unsigned count);
    int unsigned n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) < 8) begin
        send_reading(FUNC_TEMP, {8'($urandom()), 16'($urandom_range(20000, 40000))});
        n++;
        repeat ($urandom_range(1, 4)) begin
          send_reading(FUNC_PRESS, 24'($urandom()));
          n++;
        end
      end else begin
        send_reading(1'($urandom()), 24'($urandom()));
        n++;
      end
    end
  endtask

  task automatic test_slow_receiver();
    tx_idle_pct = 13;
    rx_idle_pct = 87;
    for (int i = 0; i < 4; i++) begin
      load_random_calibration(2'(i));
      random_readings(55);
      drain_results();
    end
  endtask

  task automatic test_slow_sender();
    tx_idle_pct = 87;
    rx_idle_pct = 13;
    for (int i = 0; i < 4; i++) begin
      load_random_calibration(2'(3 - i));
      random_readings(30);
      // sender pauses until every expected result has come
      drain_results();
      random_readings(25);
      drain_results();
    end
  endtask

  task automatic test_back_to_back();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 4; i++) begin
      load_random_calibration(2'($urandom()));
      // receiver held off while the sender keeps offering, input stalls
      if (i == 1) hold_req = hold_req + 1;
      random_readings(55);
      drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_if.valid = 1'b0;
    sample_if.func = FUNC_TEMP;
    sample_if.raw_reading = '0;
    result_if.ready = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 0;
    cal_a123 = '0;
    cal_a456 = '0;
    cal_b12 = '0;
    cal_mcmd = '0;
    cal_oss = 2'd1;
    kept_b5 = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_slow_receiver();
    test_slow_sender();
    test_back_to_back();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_pressure_temperature_compensation: clean");
    end else begin
      $display("tb_pressure_temperature_compensation: errors");
    end
    $finish;
  end

endmodule

// File: pressure_temperature_compensation.f
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_stream_if.sv
rtl/ptc_serial_unit.sv
rtl/pressure_temperature_compensation.sv
dv/tb_pressure_temperature_compensation.sv
